// ===== sv/mf3_pkg.sv =====
// Shared types, constants and register codes of the 3x3 median filter.
package mf3_pkg;

  localparam int MF3_MAX_WIDTH = 2048;
  localparam int FIFO_DEPTH = 16;
  localparam int PIX_W = 8;
  localparam int DIM_W = 12;
  localparam int NBR = 9;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NBR-1:0][PIX_W-1:0] win_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_GRAY = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam pix_t MAX_GRAY_RST = 8'd255;

  typedef struct packed {
    pix_t newer;
    pix_t older;
  } lines_t;

  typedef struct packed {
    pix_t pix;
    logic eor;
    logic eof;
  } res_t;

  typedef struct packed {
    logic en;
    res_t res;
  } beat_t;

  typedef struct packed {
    beat_t first;
    logic  use_median;
    beat_t second;
  } slots_t;

endpackage

// ===== sv/mf3_line_store.sv =====
// Two-row line store: one word per column, registered read, with bypass.
module mf3_line_store #(
  parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output mf3_pkg::lines_t              rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  mf3_pkg::lines_t              wr_data
);
  import mf3_pkg::*;

  lines_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== sv/mf3_median.sv =====
// Two-stage 3x3 median network with clamp; carries the result slots alongside.
module mf3_median (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  mf3_pkg::win_t   win,
  input  mf3_pkg::slots_t in_slots,
  input  mf3_pkg::pix_t   max_gray,
  output logic            out_valid,
  output mf3_pkg::slots_t out_slots
);
  import mf3_pkg::*;

  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo;
  } sorted_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic sorted_t sort3(pix_t a, pix_t b, pix_t c);
    sorted_t s;
    s.lo = min2(min2(a, b), c);
    s.hi = max2(max2(a, b), c);
    s.mid = med3(a, b, c);
    return s;
  endfunction

  sorted_t rows [3];
  logic    v1;
  slots_t  slots1;
  pix_t    lo_max;
  pix_t    mid_med;
  pix_t    hi_min;
  logic    v2;
  slots_t  slots2;
  pix_t    med;
  pix_t    clamped;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      rows[r] <= sort3(win[r*3], win[r*3+1], win[r*3+2]);
    end
    slots1 <= in_slots;
    lo_max <= max2(max2(rows[0].lo, rows[1].lo), rows[2].lo);
    mid_med <= med3(rows[0].mid, rows[1].mid, rows[2].mid);
    hi_min <= min2(min2(rows[0].hi, rows[1].hi), rows[2].hi);
    slots2 <= slots1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_comb begin
    med = med3(lo_max, mid_med, hi_min);
    clamped = (med > max_gray) ? max_gray : med;
    out_slots = slots2;
    if (slots2.use_median) begin
      out_slots.first.res.pix = clamped;
    end
  end

  assign out_valid = v2;

endmodule

// ===== sv/mf3_out_fifo.sv =====
// Output queue that takes up to two result beats per cycle and hands out one per cycle while out_ready is high.
module mf3_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mf3_pkg::beat_t push_a,
  input  mf3_pkg::beat_t push_b,
  output logic           out_valid,
  input  logic           out_ready,
  output mf3_pkg::res_t  out_res
);
  import mf3_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  res_t          mem [FIFO_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   count;
  logic          en_a;
  logic          en_b;
  logic [1:0]    n_push;
  logic          pop;
  logic [PW-1:0] wp_1;

  assign en_a = in_valid && push_a.en;
  assign en_b = in_valid && push_b.en;
  assign n_push = {1'b0, en_a} + {1'b0, en_b};
  assign pop = out_valid && out_ready;
  assign wp_1 = wp + PW'(1);

  always_ff @(posedge clk) begin
    priority if (en_a && en_b) begin
      mem[wp] <= push_a.res;
      mem[wp_1] <= push_b.res;
    end else if (en_a) begin
      mem[wp] <= push_a.res;
    end else if (en_b) begin
      mem[wp] <= push_b.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + PW'(n_push);
      if (pop) begin
        rp <= rp + PW'(1);
      end
      count <= count + (PW+1)'(n_push) - (PW+1)'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_res = mem[rp];

endmodule

// ===== sv/median_filter_3x3_stream_top.sv =====
// Top level of the streaming 3x3 median filter.
// Pixels enter in raster order as beats with s_tuser low; after the frame, beats with s_tuser
// high drain the last row, one pixel each. The block takes one input beat per clock while
// s_tready is high: the line store RAM is read when a beat is taken and written back in the
// next cycle, and the median network is two register stages deep; a pixel's results pass
// the s1 and s2 registers, both median stages and the output queue before they appear. The
// last pixel of each row after the first yields two output beats, which a 16-entry output
// queue absorbs; s_tready drops only when that queue and the beats still in the pipeline
// could fill it. The line store holds MAX_WIDTH words and needs no clearing after reset.
// Configuration writes take effect at once and belong to idle periods.
module median_filter_3x3_stream_top #(
  parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel_in
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // pixel_out
  output logic        m_tlast,
  output logic        m_tuser,   // end_of_frame
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = ((WW > DIM_W) ? WW : DIM_W) + 1;
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  pix_t             max_gray;

  logic [DIM_W-1:0] in_row;
  logic [CW-1:0]    in_col;
  logic [CW-1:0]    drain_col;

  logic [EW-1:0]    fw_ext;
  logic [EW-1:0]    w_used;
  logic [DIM_W-1:0] h_used;
  logic             draining;
  logic             col_last;
  logic             drain_last;
  logic             accept;
  logic             pix_go;
  logic             drain_go;

  logic             s1_valid;
  logic             s1_pix_go;
  logic             s1_drain_go;
  logic             s1_last;
  logic [CW-1:0]    s1_col;
  pix_t             s1_pix;
  logic             s1_row_ge1;
  logic             s1_col_ge1;
  logic             s1_inner;

  lines_t           rd_data;
  lines_t           wr_data;
  logic             wr_en;
  win_t             window;
  win_t             window_next;
  slots_t           s1_slots;

  logic             s2_valid;
  slots_t           s2_slots;

  logic             med_valid;
  slots_t           med_slots;
  res_t             head;

  logic [OCC_W-1:0] occ;
  logic [OCC_W:0]   occ_next;
  logic [1:0]       used;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      max_gray <= MAX_GRAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_MAX_GRAY:     max_gray <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = EW'(frame_width);
    if (fw_ext < EW'(2)) begin
      w_used = EW'(2);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w_used = EW'(MAX_WIDTH);
    end else begin
      w_used = fw_ext;
    end
    h_used = (frame_height < DIM_W'(2)) ? DIM_W'(2) : frame_height;
  end

  assign draining = (in_row >= h_used);
  assign col_last = ((EW'(in_col) + EW'(1)) >= w_used);
  assign drain_last = ((EW'(drain_col) + EW'(1)) >= w_used);
  assign accept = s_tvalid && s_tready;
  assign pix_go = accept && (s_tuser == OP_PIXEL) && !draining;
  assign drain_go = accept && (s_tuser == OP_DRAIN) && draining;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
      drain_col <= '0;
    end else if (pix_go) begin
      if (col_last) begin
        in_col <= '0;
        in_row <= in_row + DIM_W'(1);
        drain_col <= '0;
      end else begin
        in_col <= in_col + CW'(1);
      end
    end else if (drain_go) begin
      if (drain_last) begin
        in_row <= '0;
        in_col <= '0;
        drain_col <= '0;
      end else begin
        drain_col <= drain_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_pix_go <= 1'b0;
      s1_drain_go <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_pix_go <= pix_go;
      s1_drain_go <= drain_go;
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= pix_go ? col_last : drain_last;
    s1_col <= in_col;
    s1_pix <= s_tdata;
    s1_row_ge1 <= (in_row >= DIM_W'(1));
    s1_col_ge1 <= (in_col >= CW'(1));
    s1_inner <= (in_row >= DIM_W'(2)) && (in_col >= CW'(2));
  end

  mf3_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (pix_go || drain_go),
    .rd_addr (pix_go ? in_col : drain_col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  assign wr_en = s1_pix_go;
  assign wr_data = '{newer: s1_pix, older: rd_data.newer};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r*3] = window[r*3+1];
      window_next[r*3+1] = window[r*3+2];
    end
    window_next[2] = rd_data.older;
    window_next[5] = rd_data.newer;
    window_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_pix_go) begin
      window <= window_next;
    end
  end

  always_comb begin
    s1_slots.first.en = (s1_pix_go && s1_row_ge1 && s1_col_ge1) || s1_drain_go;
    s1_slots.first.res.pix = s1_drain_go ? rd_data.newer : window[5];
    s1_slots.first.res.eor = s1_drain_go && s1_last;
    s1_slots.first.res.eof = s1_drain_go && s1_last;
    s1_slots.use_median = s1_pix_go && s1_inner;
    s1_slots.second.en = s1_pix_go && s1_row_ge1 && s1_last;
    s1_slots.second.res.pix = rd_data.newer;
    s1_slots.second.res.eor = 1'b1;
    s1_slots.second.res.eof = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_slots <= s1_slots;
  end

  mf3_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .win       (window),
    .in_slots  (s2_slots),
    .max_gray  (max_gray),
    .out_valid (med_valid),
    .out_slots (med_slots)
  );

  mf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (med_valid),
    .push_a    (med_slots.first),
    .push_b    (med_slots.second),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head)
  );

  assign m_tdata = head.pix;
  assign m_tlast = head.eor;
  assign m_tuser = head.eof;

  // Every accepted beat reserves two queue entries until its results are pushed.
  assign pop = m_tvalid && m_tready;
  assign used = {1'b0, med_slots.first.en} + {1'b0, med_slots.second.en};

  always_comb begin
    occ_next = (OCC_W+1)'(occ);
    if (accept) begin
      occ_next = occ_next + (OCC_W+1)'(2);
    end
    if (med_valid) begin
      occ_next = occ_next - (OCC_W+1)'(2) + (OCC_W+1)'(used);
    end
    if (pop) begin
      occ_next = occ_next - (OCC_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next[OCC_W-1:0];
    end
  end

  assign s_tready = ((OCC_W+1)'(occ) <= (OCC_W+1)'(FIFO_DEPTH - 2));

endmodule

// ===== sv/mf3_checker.sv =====
// Port-level checks of the median filter top level, bound to it.
module mf3_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  a_eof_ends_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("End of frame without end of row.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("Output beat changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output beat present right after reset.");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("Input not ready right after reset.");

endmodule

bind median_filter_3x3_stream_top mf3_checker u_mf3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the streaming 3x3 median filter with random frames and drains.
`timescale 1ns / 1ps

module tb_top;
  import mf3_pkg::*;

  localparam int LINE_W = MF3_MAX_WIDTH;
  localparam int MID_POS = 4;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic op;
    pix_t px;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  feed_t pixel_feed [$];
  res_t  owed_pixels [$];
  logic  beat_taken = 1'b0;
  int    beats_in = 0;
  int    mismatches = 0;
  int    idle_pct = 37;
  int    squeeze_at = 32'h7fffffff;

  // Filter state as the block should hold it.
  logic [11:0] reg_width = FRAME_WIDTH_RST;
  logic [11:0] reg_height = FRAME_HEIGHT_RST;
  pix_t        reg_gray = MAX_GRAY_RST;
  pix_t        older_row [LINE_W] = '{default: '0};
  pix_t        newer_row [LINE_W] = '{default: '0};
  pix_t        nbhd [NBR] = '{default: '0};
  logic [11:0] cur_row = '0;
  logic [10:0] cur_col = '0;
  logic [11:0] drain_pos = '0;

  median_filter_3x3_stream_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int frame_cols();
    int w;
    w = reg_width;
    if (w < 2) w = 2;
    if (w > LINE_W) w = LINE_W;
    return w;
  endfunction

  function automatic int frame_rows();
    int h;
    h = reg_height;
    if (h < 2) h = 2;
    return h;
  endfunction

  function automatic pix_t window_median();
    pix_t s [NBR];
    pix_t t;
    for (int i = 0; i < NBR; i++) s[i] = nbhd[i];
    for (int i = 0; i < NBR - 1; i++) begin
      for (int j = 0; j < NBR - 1 - i; j++) begin
        if (s[j] > s[j+1]) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
      end
    end
    return s[MID_POS];
  endfunction

  function automatic void owe(pix_t p, logic eor, logic eof);
    res_t r;
    r = '{pix: p, eor: eor, eof: eof};
    owed_pixels.insert(owed_pixels.size(), r);
  endfunction

  function automatic void filter_step(logic op, pix_t px);
    int   w, h, c;
    logic last;
    pix_t up, mid, v;
    w = frame_cols();
    h = frame_rows();
    if (op == OP_DRAIN) begin
      if (int'(cur_row) < h) return;
      c = (int'(drain_pos) >= LINE_W) ? LINE_W - 1 : int'(drain_pos);
      last = (int'(drain_pos) + 1 >= w);
      owe(newer_row[c], last, last);
      if (last) begin
        cur_row = '0;
        cur_col = '0;
        drain_pos = '0;
      end else begin
        drain_pos = drain_pos + 1'b1;
      end
      return;
    end
    if (int'(cur_row) >= h) return;
    c = (int'(cur_col) >= LINE_W) ? LINE_W - 1 : int'(cur_col);
    up = older_row[c];
    mid = newer_row[c];
    older_row[c] = mid;
    newer_row[c] = px;
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3] = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = up;
    nbhd[5] = mid;
    nbhd[8] = px;
    last = (int'(cur_col) + 1 >= w);
    if (cur_row >= 1) begin
      if (cur_col >= 1) begin
        if (cur_row >= 2 && cur_col >= 2) begin
          v = window_median();
          if (v > reg_gray) v = reg_gray;
        end else begin
          v = nbhd[4];
        end
        owe(v, 1'b0, 1'b0);
      end
      if (last) owe(nbhd[5], 1'b1, 1'b0);
    end
    if (last) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
      drain_pos = '0;
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endfunction

  // Input side: a beat stays offered until it is taken.
  always @(negedge clk) begin : driver
    feed_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beat_taken) begin
      if (pixel_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pixel_feed.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= nxt.op;
        s_tdata <= nxt.px;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side, with one long hold-off so the output queue fills and stalls the input.
  always @(negedge clk) begin : receiver
    int squeeze_left;
    bit squeeze_done;
    if (rst) begin
      m_tready <= 1'b0;
      squeeze_left = 0;
      squeeze_done = 0;
    end else if (squeeze_left > 0) begin
      m_tready <= 1'b0;
      squeeze_left--;
    end else if (!squeeze_done && beats_in >= squeeze_at) begin
      m_tready <= 1'b0;
      squeeze_done = 1;
      squeeze_left = 400;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    res_t got, want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= s_tvalid && s_tready;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  reg_width = cfg_data;
          REG_FRAME_HEIGHT: reg_height = cfg_data;
          REG_MAX_GRAY:     reg_gray = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        beats_in++;
        filter_step(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        got = '{pix: m_tdata, eor: m_tlast, eof: m_tuser};
        if (owed_pixels.size() == 0) begin
          $error("unexpected output beat: pixel_out %0d", m_tdata);
          mismatches++;
        end else begin
          want = owed_pixels.pop_front();
          if (got.pix !== want.pix) begin
            $error("pixel_out: expected %0d, got %0d", want.pix, got.pix);
            mismatches++;
          end
          if (got.eor !== want.eor) begin
            $error("end_of_row: expected %0b, got %0b", want.eor, got.eor);
            mismatches++;
          end
          if (got.eof !== want.eof) begin
            $error("end_of_frame: expected %0b, got %0b", want.eof, got.eof);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic pix_t rand_pixel();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 15) return 8'h00;
    if (k < 30) return 8'hFF;
    return pix_t'($urandom_range(255));
  endfunction

  function automatic logic [11:0] pick_width();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 10) return 12'($urandom_range(1));
    if (k < 65) return 12'($urandom_range(8, 2));
    if (k < 90) return 12'($urandom_range(40, 9));
    return 12'($urandom_range(100, 41));
  endfunction

  function automatic logic [11:0] pick_height();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 15) return 12'($urandom_range(1));
    if (k < 80) return 12'($urandom_range(5, 2));
    return 12'($urandom_range(10, 6));
  endfunction

  function automatic pix_t pick_gray();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 30) return 8'd255;
    if (k < 40) return 8'd0;
    if (k < 50) return 8'd1;
    return pix_t'($urandom_range(255));
  endfunction

  task automatic feed(input logic op, input pix_t px);
    feed_t f;
    f = '{op: op, px: px};
    pixel_feed.insert(pixel_feed.size(), f);
  endtask

  task automatic feed_pixels(input int n);
    for (int i = 0; i < n; i++) feed(OP_PIXEL, rand_pixel());
  endtask

  // A pixel slipped in while draining is ignored; a drain after the frame ends does nothing.
  task automatic feed_drains(input int n, input bit closing);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) feed(OP_PIXEL, rand_pixel());
      feed(OP_DRAIN, rand_pixel());
    end
    if (closing && $urandom_range(9) == 0) feed(OP_DRAIN, rand_pixel());
  endtask

  // Completes the frame from wherever the filter stands now; call only while idle.
  task automatic finish_frame();
    int w, h, n;
    w = frame_cols();
    h = frame_rows();
    if (int'(cur_row) < h) begin
      n = (int'(cur_col) >= w) ? 1 : w - int'(cur_col);
      n += (h - int'(cur_row) - 1) * w;
      feed_pixels(n);
      feed_drains(w, 1);
    end else begin
      feed_drains((int'(drain_pos) >= w) ? 1 : w - int'(drain_pos), 1);
    end
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pixel_feed.size() != 0 || s_tvalid || owed_pixels.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  initial begin : stimulus
    int w, h, kind, start, n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    feed(OP_DRAIN, 8'h5A);
    settle();
    set_reg(REG_FRAME_WIDTH, 12'd3);
    set_reg(REG_FRAME_HEIGHT, 12'd3);
    set_reg(REG_MAX_GRAY, 12'd100);
    set_reg(REG_NONE, 12'hFFF);
    // The center median is 255 and must be clamped to the gray limit.
    feed(OP_PIXEL, 8'd255); feed(OP_PIXEL, 8'd0);   feed(OP_PIXEL, 8'd255);
    feed(OP_PIXEL, 8'd255); feed(OP_PIXEL, 8'd200); feed(OP_PIXEL, 8'd255);
    feed(OP_PIXEL, 8'd0);   feed(OP_PIXEL, 8'd255); feed(OP_PIXEL, 8'd128);
    feed(OP_DRAIN, 8'h00);
    feed(OP_PIXEL, 8'hFF);
    feed(OP_DRAIN, 8'hFF);
    feed(OP_DRAIN, 8'h00);
    feed(OP_DRAIN, 8'h00);
    settle();
    set_reg(REG_FRAME_WIDTH, 12'd2);
    set_reg(REG_FRAME_HEIGHT, 12'd2);
    set_reg(REG_MAX_GRAY, 12'hFFF);
    feed(OP_PIXEL, 8'd0); feed(OP_PIXEL, 8'd255); feed(OP_PIXEL, 8'd1); feed(OP_PIXEL, 8'd128);
    feed(OP_DRAIN, 8'h00); feed(OP_DRAIN, 8'h00);
    settle();

    start = beats_in;
    while (beats_in - start < 700) begin
      kind = $urandom_range(9);
      if ($urandom_range(3) != 0) set_reg(REG_FRAME_WIDTH, pick_width());
      if ($urandom_range(3) != 0) set_reg(REG_FRAME_HEIGHT, pick_height());
      if ($urandom_range(2) == 0) set_reg(REG_MAX_GRAY, {4'($urandom_range(15)), pick_gray()});
      if ($urandom_range(15) == 0) set_reg(REG_NONE, 12'($urandom_range(4095)));
      w = frame_cols();
      h = frame_rows();
      if ($urandom_range(7) == 0) feed(OP_DRAIN, rand_pixel());
      if (kind < 6) begin
        finish_frame();
      end else begin
        // Stop partway, then narrow the frame or move its height before finishing it.
        if (kind < 8) begin
          feed_pixels($urandom_range(w * h - 1, 1));
        end else begin
          feed_pixels(w * h);
          feed_drains($urandom_range(w - 1, 0), 0);
        end
        settle();
        set_reg(REG_FRAME_WIDTH, 12'($urandom_range(w, 0)));
        if ($urandom_range(1)) set_reg(REG_FRAME_HEIGHT, 12'($urandom_range(cur_row + 3, 0)));
        finish_frame();
      end
      settle();
    end

    set_reg(REG_FRAME_WIDTH, 12'd3);
    set_reg(REG_FRAME_HEIGHT, 12'd4095);
    feed_pixels(30);
    settle();
    set_reg(REG_FRAME_HEIGHT, 12'd4);
    finish_frame();
    settle();

    set_reg(REG_FRAME_WIDTH, 12'd4095);
    set_reg(REG_FRAME_HEIGHT, 12'd2);
    feed_pixels(5);
    settle();
    set_reg(REG_FRAME_WIDTH, 12'd4);
    finish_frame();
    settle();

    idle_pct = 0;
    set_reg(REG_FRAME_WIDTH, 12'd256);
    set_reg(REG_FRAME_HEIGHT, 12'd2);
    set_reg(REG_MAX_GRAY, 12'd255);
    squeeze_at = beats_in + 300;
    finish_frame();
    settle();
    idle_pct = 37;

    set_reg(REG_FRAME_WIDTH, pick_width());
    set_reg(REG_MAX_GRAY, 12'd0);
    finish_frame();

    n = 0;
    while ((pixel_feed.size() != 0 || s_tvalid || owed_pixels.size() != 0) && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (24) @(posedge clk);
    if (owed_pixels.size() != 0) begin
      $error("%0d expected output beats never arrived", owed_pixels.size());
      mismatches++;
    end
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #1_500_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mf3_pkg.sv
sv/mf3_line_store.sv
sv/mf3_median.sv
sv/mf3_out_fifo.sv
sv/median_filter_3x3_stream_top.sv
sv/mf3_checker.sv
dv/tb_top.sv
